// ----- rtl/cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// cbb_pkg
// shared types, step codes and band-pass coefficient table for the cascaded
// biquad filter
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int TABLE_FRAC = 24;
  localparam int TABLE_ROWS = 3;
  localparam int SEC_BITS   = 3;

  // coefficient columns
  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  typedef enum logic [2:0] {
    STEP_B0 = 3'd0,
    STEP_Y  = 3'd1,
    STEP_A1 = 3'd2,
    STEP_FD = 3'd3,
    STEP_A2 = 3'd4,
    STEP_SD = 3'd5
  } step_e;

  typedef struct packed {
    logic                load;
    logic                run;
    step_e               step;
    logic [SEC_BITS-1:0] sec;
    logic                take;
  } cbb_cmd_t;

  // b0, b1, b2, a1, a2 with 24 fractional bits
  localparam logic signed [31:0] COEF_TABLE [TABLE_ROWS][5] = '{
    '{32'sd3465703,  32'sd0,         -32'sd3465703,  -32'sd6199634,  32'sd9845793},
    '{32'sd16777216, 32'sd33554432,  32'sd16777216,  -32'sd19176022, 32'sd6925668},
    '{32'sd15755333, -32'sd31510665, 32'sd15755333,  -32'sd31489056, 32'sd14758497}
  };

  // coefficient rounded half away from zero to frac fractional bits
  function automatic logic signed [31:0] coef_value(input logic [SEC_BITS-1:0] sec,
                                                    input logic [2:0] k,
                                                    input int frac);
    logic signed [31:0] v;
    logic signed [31:0] mag;
    logic signed [31:0] r;
    int d;
    d = TABLE_FRAC - frac;
    if (sec >= SEC_BITS'(TABLE_ROWS)) begin
      return (k == COEF_B0) ? (32'sd1 <<< frac) : 32'sd0;
    end
    v   = COEF_TABLE[sec[1:0]][k];
    mag = (v < 0) ? -v : v;
    r   = (mag + (32'sd1 <<< (d - 1))) >>> d;
    return (v < 0) ? -r : r;
  endfunction

endpackage

// ----- rtl/cascaded_biquad_bandpass.sv -----
// ----------------------------------------------------------------------------
// cascaded_biquad_bandpass
// band-pass filter of cascaded transposed direct form II biquad sections
// ----------------------------------------------------------------------------
// Each sample passes through taking the request, six steps per section on
// the single shared multiplier (five products, with the output rounding
// alongside the second one, plus the second delay write), and holding the
// result on the master side; a new request is taken once the result is gone.
// Section outputs saturate to the sample width and delays to 32 bits. A
// request with tlast set clears every section delay once its result is taken,
// so the next sample starts from rest.
module cascaded_biquad_bandpass #(
  parameter int SECTIONS       = 3,
  parameter int COEF_FRAC_BITS = 14,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,  // sample_in
  input  logic                                 s_axis_tlast_i,  // block_end
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata_o,  // sample_out
  output logic                                 m_axis_tlast_o   // block_end_out
);
  import cbb_pkg::*;

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  cbb_cmd_t                      cmd;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  cbb_ctrl #(
    .SECTIONS(SECTIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd)
  );

  cbb_datapath #(
    .SECTIONS      (SECTIONS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_sample_i (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .in_last_i   (s_axis_tlast_i),
    .out_sample_o(out_sample),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(DATA_W-SAMPLE_BITS){1'b0}}, out_sample};

endmodule

// ----- rtl/cbb_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbb_ctrl
// sequencer: takes one request, walks six steps per section over the shared
// multiplier, then holds the result until it is taken
// ----------------------------------------------------------------------------
module cbb_ctrl #(
  parameter int SECTIONS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cbb_pkg::cbb_cmd_t cmd_o
);
  import cbb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic [SEC_BITS-1:0] LAST_SEC = SEC_BITS'(SECTIONS - 1);

  logic [1:0]          state_q, state_d;
  step_e               step_q, step_d;
  logic [SEC_BITS-1:0] sec_q, sec_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    sec_d      = sec_q;
    cmd_o.load = 1'b0;
    cmd_o.run  = 1'b0;
    cmd_o.step = step_q;
    cmd_o.sec  = sec_q;
    cmd_o.take = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          step_d     = STEP_B0;
          sec_d      = '0;
        end
      end
      ST_RUN: begin
        cmd_o.run = 1'b1;
        if (step_q == STEP_SD) begin
          step_d = STEP_B0;
          if (sec_q == LAST_SEC) begin
            state_d = ST_OUT;
          end else begin
            sec_d = sec_q + 1'b1;
          end
        end else begin
          step_d = step_e'(step_q + 3'd1);
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_B0;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sec_q   <= sec_d;
    end
  end

endmodule

// ----- rtl/cbb_datapath.sv -----
// ----------------------------------------------------------------------------
// cbb_datapath
// shared multiplier with product register, accumulator, section delays and
// rounding / saturation of section outputs and delays
// ----------------------------------------------------------------------------
module cbb_datapath #(
  parameter int SECTIONS       = 3,
  parameter int COEF_FRAC_BITS = 14,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbb_pkg::cbb_cmd_t             cmd_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                          in_last_i,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o,
  output logic                          out_last_o
);
  import cbb_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 3;
  localparam int PW = CW + SAMPLE_BITS;
  localparam int AW = ((PW > 32) ? PW : 32) + 2;
  localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  localparam logic signed [AW-1:0] HALF  =
    {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] Y_MAX =
    {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [AW-1:0] D_MAX = {{(AW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [AW-1:0] D_MIN = ~D_MAX;

  logic signed [SAMPLE_BITS-1:0] x_q, y_q;
  logic                          blk_q;
  logic signed [PW-1:0]          prod_q, prod_d;
  logic signed [AW-1:0]          acc_q;
  logic signed [31:0]            fd_q [SECTIONS];
  logic signed [31:0]            sd_q [SECTIONS];

  logic [SW-1:0]                 sec;
  logic [2:0]                    coef_k;
  logic                          use_y;
  logic signed [31:0]            coef_full;
  logic signed [CW-1:0]          coef_w;
  logic signed [SAMPLE_BITS-1:0] op_w;
  logic signed [AW-1:0]          prod_ext, fd_ext, sd_ext;
  logic signed [AW-1:0]          y_sum, y_shift, fd_sum, sd_sum;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [31:0]            fd_sat, sd_sat;

  assign sec = cmd_i.sec[SW-1:0];

  always_comb begin
    coef_k = COEF_B0;
    use_y  = 1'b0;
    case (cmd_i.step)
      STEP_B0: coef_k = COEF_B0;
      STEP_Y:  coef_k = COEF_B1;
      STEP_A1: begin
        coef_k = COEF_A1;
        use_y  = 1'b1;
      end
      STEP_FD: coef_k = COEF_B2;
      STEP_A2: begin
        coef_k = COEF_A2;
        use_y  = 1'b1;
      end
      default: coef_k = COEF_B0;
    endcase
  end

  assign coef_full = coef_value(cmd_i.sec, coef_k, COEF_FRAC_BITS);
  assign coef_w    = coef_full[CW-1:0];
  assign op_w      = use_y ? y_q : x_q;
  assign prod_d    = coef_w * op_w;

  assign prod_ext = {{(AW-PW){prod_q[PW-1]}}, prod_q};
  assign fd_ext   = {{(AW-32){fd_q[sec][31]}}, fd_q[sec]};
  assign sd_ext   = {{(AW-32){sd_q[sec][31]}}, sd_q[sec]};

  // section output: round half up, saturate to sample width
  assign y_sum   = prod_ext + fd_ext + HALF;
  assign y_shift = y_sum >>> COEF_FRAC_BITS;
  always_comb begin
    if (y_shift > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (y_shift < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_shift[SAMPLE_BITS-1:0];
    end
  end

  // delay updates, saturated to 32 bits
  assign fd_sum = acc_q - prod_ext + sd_ext;
  assign sd_sum = acc_q - prod_ext;
  always_comb begin
    if (fd_sum > D_MAX) begin
      fd_sat = D_MAX[31:0];
    end else if (fd_sum < D_MIN) begin
      fd_sat = D_MIN[31:0];
    end else begin
      fd_sat = fd_sum[31:0];
    end
    if (sd_sum > D_MAX) begin
      sd_sat = D_MAX[31:0];
    end else if (sd_sum < D_MIN) begin
      sd_sat = D_MIN[31:0];
    end else begin
      sd_sat = sd_sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= in_sample_i;
      blk_q <= in_last_i;
    end
    if (cmd_i.run) begin
      prod_q <= prod_d;
      case (cmd_i.step)
        STEP_Y:  y_q   <= y_sat;
        STEP_A1: acc_q <= prod_ext;
        STEP_A2: acc_q <= prod_ext;
        STEP_SD: x_q   <= y_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        fd_q[i] <= '0;
        sd_q[i] <= '0;
      end
    end else if (cmd_i.take && blk_q) begin
      for (int i = 0; i < SECTIONS; i++) begin
        fd_q[i] <= '0;
        sd_q[i] <= '0;
      end
    end else if (cmd_i.run) begin
      if (cmd_i.step == STEP_FD) begin
        fd_q[sec] <= fd_sat;
      end
      if (cmd_i.step == STEP_SD) begin
        sd_q[sec] <= sd_sat;
      end
    end
  end

  assign out_sample_o = y_q;
  assign out_last_o   = blk_q;

endmodule

// ----- rtl/cbb_checker.sv -----
// ----------------------------------------------------------------------------
// cbb_checker
// port-level checks of the filter's stream handshakes
// ----------------------------------------------------------------------------
module cbb_checker #(
  parameter int DATA_W = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [DATA_W-1:0] m_axis_tdata_o,
  input logic              m_axis_tlast_o
);

  // result held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped before taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("request taken while result pending");

  // a taken request is not answered at once by a result or by ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !m_axis_tvalid_o && !s_axis_tready_o)
    else $error("result or ready too early after request");

  // no repeated result once a result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=> !m_axis_tvalid_o)
    else $error("repeated result");

endmodule

bind cascaded_biquad_bandpass cbb_checker #(.DATA_W(DATA_W)) u_cbb_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for cascaded_biquad_bandpass: samples are streamed in on
// the slave side, a bit-true model of the three fixed-point biquad sections
// predicts each filtered sample, and the master side is checked in order,
// with random idling on both sides, a long receiver hold-off and block resets
// ----------------------------------------------------------------------------
module tb;

  localparam int SECTIONS       = 3;
  localparam int COEF_FRAC_BITS = 14;
  localparam int SAMPLE_BITS    = 16;
  localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int TAB_FRAC       = 24;
  localparam int TAB_ROWS       = 3;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {
    MODE_FULL,
    MODE_SMALL,
    MODE_EXTREME,
    MODE_SQUARE
  } stim_mode_e;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          last;
  } filt_result_t;

  // b0, b1, b2, a1, a2 with 24 fractional bits
  localparam longint BQ_TABLE [TAB_ROWS][5] = '{
    '{64'sd3465703,  64'sd0,         -64'sd3465703, -64'sd6199634,  64'sd9845793},
    '{64'sd16777216, 64'sd33554432,  64'sd16777216, -64'sd19176022, 64'sd6925668},
    '{64'sd15755333, -64'sd31510665, 64'sd15755333, -64'sd31489056, 64'sd14758497}
  };

  logic                  clk_i      = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  s_valid    = 1'b0;
  logic [TDATA_BITS-1:0] s_data     = '0;
  logic                  s_last     = 1'b0;
  logic                  m_ready    = 1'b0;
  logic                  no_idle    = 1'b0;
  int                    hold_req   = 0;
  int                    hold_seen  = 0;
  int                    hold_left  = 0;
  int                    err_cnt    = 0;

  logic                  s_ready;
  logic                  m_valid;
  logic [TDATA_BITS-1:0] m_data;
  logic                  m_last;

  logic signed [31:0]    z1_st [SECTIONS];
  logic signed [31:0]    z2_st [SECTIONS];
  filt_result_t          filt_q [$];

  cascaded_biquad_bandpass #(
    .SECTIONS       (SECTIONS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // sample_in
    .s_axis_tlast_i  (s_last),   // block_end
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // sample_out
    .m_axis_tlast_o  (m_last)    // block_end_out
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end

  function automatic longint coef_fixed(input int s, input int k);
    longint v;
    longint mag;
    longint r;
    int     d;
    d = TAB_FRAC - COEF_FRAC_BITS;
    if (s >= TAB_ROWS) begin
      return (k == 0) ? (64'sd1 <<< COEF_FRAC_BITS) : 64'sd0;
    end
    v = BQ_TABLE[s][k];
    if (d <= 0) begin
      return v;
    end
    mag = (v < 0) ? -v : v;
    r   = (mag + (64'sd1 <<< (d - 1))) >>> d;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic void clear_delays();
    for (int s = 0; s < SECTIONS; s++) begin
      z1_st[s] = '0;
      z2_st[s] = '0;
    end
  endfunction

  // runs one sample through every section and updates the delay line, clearing it on a block's last sample
  function automatic logic signed [SAMPLE_BITS-1:0] bandpass_step(
      input logic signed [SAMPLE_BITS-1:0] x_in, input logic last);
    longint x;
    longint y;
    longint acc;
    x = x_in;
    y = 0;
    for (int s = 0; s < SECTIONS; s++) begin
      acc      = coef_fixed(s, 0) * x + longint'(z1_st[s]);
      y        = clamp((acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS,
                       SAMPLE_BITS);
      z1_st[s] = 32'(clamp(coef_fixed(s, 1) * x - coef_fixed(s, 3) * y
                           + longint'(z2_st[s]), 32));
      z2_st[s] = 32'(clamp(coef_fixed(s, 2) * x - coef_fixed(s, 4) * y, 32));
      x        = y;
    end
    if (last) begin
      clear_delays();
    end
    return y[SAMPLE_BITS-1:0];
  endfunction

  // receiver side with random idling and requested hold-offs
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  // result check first, then prediction of the request taken at this edge
  always @(posedge clk_i) begin
    filt_result_t exp_r;
    logic signed [SAMPLE_BITS-1:0] got;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        got = m_data[SAMPLE_BITS-1:0];
        if (filt_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("unexpected result: sample %0d last %0b", got, m_last);
          end
        end else begin
          exp_r = filt_q.pop_front();
          if (got !== exp_r.smp || m_last !== exp_r.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                       exp_r.smp, exp_r.last, got, m_last);
            end
          end
        end
      end
      if (s_valid && s_ready) begin
        exp_r.last = s_last;
        exp_r.smp  = bandpass_step(s_data[SAMPLE_BITS-1:0], s_last);
        filt_q.push_back(exp_r);
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
    while (!no_idle && $urandom_range(99) < 6) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= TDATA_BITS'(smp);
    s_last  <= last;
    do begin
      @(posedge clk_i);
    end while (!s_ready);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      input stim_mode_e mode, input int idx, input int period);
    case (mode)
      MODE_SMALL: begin
        return SAMPLE_BITS'($signed($urandom_range(511)) - 256);
      end
      MODE_EXTREME: begin
        return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
      MODE_SQUARE: begin
        return ((idx / period) % 2 != 0) ? 16'sh7fff : 16'sh8000;
      end
      default: begin
        return SAMPLE_BITS'($urandom());
      end
    endcase
  endfunction

  task automatic run_blocks(input int n_items);
    int         sent;
    int         len;
    int         period;
    stim_mode_e mode;
    sent = 0;
    while (sent < n_items) begin
      len    = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      period = $urandom_range(1, 24);
      mode   = stim_mode_e'($urandom_range(3));
      for (int i = 0; i < len; i++) begin
        send_sample(pick_sample(mode, i, period), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_directed();
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    // impulse response from rest
    send_sample(16'sh7fff, 1'b0);
    for (int i = 0; i < 5; i++) begin
      send_sample(16'sd0, 1'b0);
    end
    send_sample(16'sd0, 1'b1);
    // full-scale square wave drives sections into saturation
    for (int i = 0; i < 12; i++) begin
      send_sample(((i / 3) % 2 != 0) ? 16'sh8000 : 16'sh7fff, i == 11);
    end
  endtask

  task automatic test_random_blocks();
    run_blocks(620);
  endtask

  task automatic test_no_idle();
    no_idle <= 1'b1;
    run_blocks(200);
    no_idle <= 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    for (int i = 0; i < 16; i++) begin
      send_sample(pick_sample(MODE_FULL, i, 1), i == 15);
    end
  endtask

  initial begin
    int waited;
    clear_delays();
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_blocks();
    test_backpressure();
    test_no_idle();
    test_backpressure();
    s_valid <= 1'b0;
    waited = 0;
    while (filt_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0 && filt_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
